FILE: hw/rtl/pta_pkg.sv
// Shared types, widths and constants of the pitot traverse averager.
package pta_pkg;

   // Store capacity and derived index widths
   localparam int MAX_POINTS = 128;
   localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Field widths
   localparam int RD_W    = 24;
   localparam int COEF_W  = 17;
   localparam int VAL_W   = 32;
   localparam int MEAN_W  = 32;
   localparam int SHARE_W = 17;
   localparam int USED_W  = 8;

   localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(65536);

   // Scaling multiplier: reading times coefficient, twice
   localparam int MUL_A_W   = RD_W - 1 + COEF_W;
   localparam int PROD_W    = MUL_A_W + COEF_W;
   localparam int ROUND_BIT = 31;
   localparam int FRAC_OUT  = 32;

   // Square root of a stored value shifted up by 16
   localparam int RAD_W  = 42;
   localparam int ROOT_W = RAD_W / 2;

   // Root sum, its square and the mean divisor
   localparam int SUM_W  = ADDR_W + ROOT_W;
   localparam int SQ_W   = 2 * SUM_W;
   localparam int NSQ_W  = 2 * CNT_W;
   localparam int DEN_W  = NSQ_W + 16;
   localparam int NUM_W  = (SQ_W > CNT_W + 16) ? SQ_W : CNT_W + 16;
   localparam int REM_W  = DEN_W + 1;
   localparam int DCNT_W = $clog2(NUM_W + 1);

   // Peak compare operand
   localparam int CMP_W = VAL_W + 4;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic mul_first;
      logic mul_second;
      logic sqrt_step;
      logic accumulate;
      logic square;
      logic div_load_mean;
      logic div_load_share;
      logic div_step;
      logic mean_take;
      logic sweep_start;
      logic sweep_step;
      logic result_take;
   } pta_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic sqrt_done;
      logic div_done;
      logic sweep_done;
      logic last;
   } pta_status_type;

endpackage

FILE: hw/rtl/pitot_traverse_averager_core.sv
// Top level of the pitot traverse averager.
//
// A request (req_reading, signed Q7.16, and req_last_point) is taken at a
// rising edge with start high and busy low. Each reading is scaled by the
// squared coefficient, stored, and its square root is summed. A reading
// keeps busy high through two multiplier passes, 21 square root
// iterations of the bit-pair unit, a check that the root is finished and
// the accumulate state; the next request is taken only once busy is low.
// A request with req_last_point set adds the result phase: a squaring step,
// a divider load, a restoring divide of NUM_W = 56 steps and a finish check
// for the mean, a sweep of the point store through its single read port,
// one more load and a second divide of the same kind for the share.
// The result shows on the rsp_ ports for one cycle with rsp_valid high; the
// receiver cannot stall, and the next request may be taken in that cycle.
// Readings beyond capacity are dropped and reported through rsp_overflow.
// csr_we writes the tube coefficient (Q1.16); write it only while idle.
// Synchronous reset returns the controller to idle, clears the traverse
// sums and sets the coefficient to 1.0; the store needs no clearing pass.
module pitot_traverse_averager_core
   import pta_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [RD_W-1:0] req_reading,
   input  logic                   req_last_point,
   output logic                   rsp_valid,
   output logic [MEAN_W-1:0]      rsp_mean_velocity_pressure,
   output logic [SHARE_W-1:0]     rsp_share_above_tenth,
   output logic [USED_W-1:0]      rsp_points_used,
   output logic                   rsp_overflow,
   input  logic                   csr_we,
   input  logic [COEF_W-1:0]      csr_wdata
);

   pta_cmd_type    cmd;
   pta_status_type status;

   pta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   pta_datapath u_datapath (
      .clock                      (clock),
      .reset                      (reset),
      .req_reading                (req_reading),
      .req_last_point             (req_last_point),
      .csr_we                     (csr_we),
      .csr_wdata                  (csr_wdata),
      .cmd                        (cmd),
      .status                     (status),
      .rsp_mean_velocity_pressure (rsp_mean_velocity_pressure),
      .rsp_share_above_tenth      (rsp_share_above_tenth),
      .rsp_points_used            (rsp_points_used),
      .rsp_overflow               (rsp_overflow)
   );

endmodule

FILE: hw/rtl/pta_ram.sv
// Generic single write, single read RAM with registered read data.
module pta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/pta_ctrl.sv
// Sequencing state machine of the pitot traverse averager.
module pta_ctrl
   import pta_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   output logic           rsp_valid,
   output pta_cmd_type    cmd,
   input  pta_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL1, ST_MUL2, ST_SQRT, ST_ACC, ST_SQR,
      ST_MLOAD, ST_MDIV, ST_SWEEP, ST_SLOAD, ST_SDIV
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul_first = 1'b1;
            state_in      = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_second = 1'b1;
            state_in       = ST_SQRT;
         end
         ST_SQRT: begin
            if (status.sqrt_done) begin
               state_in = ST_ACC;
            end else begin
               cmd.sqrt_step = 1'b1;
            end
         end
         ST_ACC: begin
            cmd.accumulate = 1'b1;
            state_in       = status.last ? ST_SQR : ST_IDLE;
         end
         ST_SQR: begin
            cmd.square = 1'b1;
            state_in   = ST_MLOAD;
         end
         ST_MLOAD: begin
            cmd.div_load_mean = 1'b1;
            state_in          = ST_MDIV;
         end
         ST_MDIV: begin
            if (status.div_done) begin
               cmd.mean_take   = 1'b1;
               cmd.sweep_start = 1'b1;
               state_in        = ST_SWEEP;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_SWEEP: begin
            if (status.sweep_done) begin
               state_in = ST_SLOAD;
            end else begin
               cmd.sweep_step = 1'b1;
            end
         end
         ST_SLOAD: begin
            cmd.div_load_share = 1'b1;
            state_in           = ST_SDIV;
         end
         ST_SDIV: begin
            if (status.div_done) begin
               cmd.result_take = 1'b1;
               valid_in        = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

FILE: hw/rtl/pta_datapath.sv
// Datapath: scaling, square root, accumulation, point store, divider and sweep.
module pta_datapath
   import pta_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [RD_W-1:0]   req_reading,
   input  logic                     req_last_point,
   input  logic                     csr_we,
   input  logic [COEF_W-1:0]        csr_wdata,
   input  pta_cmd_type              cmd,
   output pta_status_type           status,
   output logic [MEAN_W-1:0]        rsp_mean_velocity_pressure,
   output logic [SHARE_W-1:0]       rsp_share_above_tenth,
   output logic [USED_W-1:0]        rsp_points_used,
   output logic                     rsp_overflow
);

   logic [COEF_W-1:0]  coef_ff;
   logic               last_ff;
   logic [MUL_A_W-1:0] mul_a_ff;
   logic [VAL_W-1:0]   v_ff;
   logic [RAD_W-1:0]   sq_x_ff, sq_res_ff, sq_bit_ff;
   logic [VAL_W-1:0]   peak_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               dropped_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [DEN_W-1:0]   dden_ff;
   logic [DCNT_W-1:0]  dcnt_ff;
   logic [CNT_W-1:0]   sw_idx_ff;
   logic               pend_ff;
   logic [CNT_W-1:0]   k_ff;
   logic [MEAN_W-1:0]  mean_ff;
   logic [SHARE_W-1:0] share_ff;
   logic [USED_W-1:0]  used_ff;
   logic               ovf_ff;

   logic [PROD_W-1:0]  prod;
   logic [PROD_W:0]    rnd_sum;
   logic [VAL_W-1:0]   v_new;
   logic [RAD_W-1:0]   trial;
   logic               has_room;
   logic [SQ_W-1:0]    sum_sq;
   logic [NSQ_W-1:0]   n_sq;
   logic [REM_W-1:0]   rem_sh;
   logic               rem_ge;
   logic               rd_en;
   logic [VAL_W-1:0]   rd_data;
   logic [CMP_W-1:0]   ten_v;

   // Shared scaling multiplier with round to nearest
   assign prod    = PROD_W'(mul_a_ff) * PROD_W'(coef_ff);
   assign rnd_sum = {1'b0, prod} + ((PROD_W + 1)'(1) << ROUND_BIT);
   assign v_new   = VAL_W'(rnd_sum >> FRAC_OUT);

   assign trial    = sq_res_ff + sq_bit_ff;
   assign has_room = (count_ff < CNT_W'(MAX_POINTS));
   assign sum_sq   = SQ_W'(sum_ff) * SQ_W'(sum_ff);
   assign n_sq     = NSQ_W'(count_ff) * NSQ_W'(count_ff);
   assign rem_sh   = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
   assign rem_ge   = (rem_sh >= {1'b0, dden_ff});
   assign rd_en    = cmd.sweep_step && (sw_idx_ff < count_ff);
   assign ten_v    = (CMP_W'(rd_data) << 3) + (CMP_W'(rd_data) << 1);

   // Point store
   pta_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_store (
      .clock   (clock),
      .wr_en   (cmd.accumulate && has_room),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (v_ff),
      .rd_en   (rd_en),
      .rd_addr (sw_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Control and traverse state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff    <= COEF_RESET;
         peak_ff    <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         sq_bit_ff  <= '0;
         dcnt_ff    <= '0;
         sw_idx_ff  <= '0;
         pend_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            coef_ff <= csr_wdata;
         end
         if (cmd.mul_second) begin
            sq_bit_ff <= RAD_W'(1) << (RAD_W - 2);
         end else if (cmd.sqrt_step) begin
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         if (cmd.accumulate) begin
            if (has_room) begin
               count_ff <= count_ff + CNT_W'(1);
               sum_ff   <= sum_ff + SUM_W'(sq_res_ff[ROOT_W-1:0]);
               if (v_ff > peak_ff) begin
                  peak_ff <= v_ff;
               end
            end else begin
               dropped_ff <= 1'b1;
            end
         end
         if (cmd.div_load_mean || cmd.div_load_share) begin
            dcnt_ff <= DCNT_W'(NUM_W);
         end else if (cmd.div_step) begin
            dcnt_ff <= dcnt_ff - DCNT_W'(1);
         end
         if (cmd.sweep_start) begin
            sw_idx_ff <= '0;
            pend_ff   <= 1'b0;
         end else if (cmd.sweep_step) begin
            pend_ff <= rd_en;
            if (rd_en) begin
               sw_idx_ff <= sw_idx_ff + CNT_W'(1);
            end
         end
         // Start a new traverse once the result is out
         if (cmd.result_take) begin
            peak_ff    <= '0;
            sum_ff     <= '0;
            count_ff   <= '0;
            dropped_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         last_ff  <= req_last_point;
         mul_a_ff <= req_reading[RD_W-1] ? '0 : MUL_A_W'($unsigned(req_reading));
      end else if (cmd.mul_first) begin
         mul_a_ff <= prod[MUL_A_W-1:0];
      end
      if (cmd.mul_second) begin
         v_ff      <= v_new;
         sq_x_ff   <= RAD_W'({v_new, 16'b0});
         sq_res_ff <= '0;
      end else if (cmd.sqrt_step) begin
         if (sq_x_ff >= trial) begin
            sq_x_ff   <= sq_x_ff - trial;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
      end
      if (cmd.square) begin
         sq_ff  <= sum_sq;
         den_ff <= {n_sq, 16'b0};
      end
      // Restoring divider, one quotient bit a cycle
      if (cmd.div_load_mean) begin
         num_ff  <= NUM_W'(sq_ff);
         dden_ff <= den_ff;
         rem_ff  <= '0;
      end else if (cmd.div_load_share) begin
         num_ff  <= NUM_W'({k_ff, 16'b0});
         dden_ff <= DEN_W'(count_ff);
         rem_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_sh - {1'b0, dden_ff} : rem_sh;
         num_ff <= {num_ff[NUM_W-2:0], rem_ge};
      end
      if (cmd.mean_take) begin
         mean_ff <= (|num_ff[NUM_W-1:MEAN_W]) ? '1 : num_ff[MEAN_W-1:0];
      end
      // Count points above a tenth of the peak
      if (cmd.sweep_start) begin
         k_ff <= '0;
      end else if (pend_ff && (ten_v > CMP_W'(peak_ff))) begin
         k_ff <= k_ff + CNT_W'(1);
      end
      if (cmd.result_take) begin
         share_ff <= num_ff[SHARE_W-1:0];
         used_ff  <= USED_W'(count_ff);
         ovf_ff   <= dropped_ff;
      end
   end

   assign status.sqrt_done  = (sq_bit_ff == '0);
   assign status.div_done   = (dcnt_ff == '0);
   assign status.sweep_done = (sw_idx_ff == count_ff) && !pend_ff;
   assign status.last       = last_ff;

   assign rsp_mean_velocity_pressure = mean_ff;
   assign rsp_share_above_tenth      = share_ff;
   assign rsp_points_used            = used_ff;
   assign rsp_overflow               = ovf_ff;

endmodule

FILE: hw/rtl/pta_checker.sv
// Port-level checks of the pitot traverse averager, bound to the top level.
module pta_checker
   import pta_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [SHARE_W-1:0] rsp_share_above_tenth
);

   // Reset leaves the block idle and silent
   assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

   // An accepted request keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted without going busy");

   // A result lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // A result is always preceded by the block being busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without preceding work");

   // The share cannot exceed one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_share_above_tenth <= SHARE_W'(65536))
      else $error("share above one");

endmodule

bind pitot_traverse_averager_core pta_checker u_pta_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .rsp_valid             (rsp_valid),
   .rsp_share_above_tenth (rsp_share_above_tenth)
);

FILE: verif/testbench.sv
// Testbench for the pitot traverse averager core: directed and random traverses.
module testbench
   import pta_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic signed [RD_W-1:0] req_reading = '0;
   logic                   req_last_point = 1'b0;
   logic                   rsp_valid;
   logic [MEAN_W-1:0]      rsp_mean_velocity_pressure;
   logic [SHARE_W-1:0]     rsp_share_above_tenth;
   logic [USED_W-1:0]      rsp_points_used;
   logic                   rsp_overflow;
   logic                   csr_we = 1'b0;
   logic [COEF_W-1:0]      csr_wdata = '0;

   typedef struct packed {
      logic [MEAN_W-1:0]  mean;
      logic [SHARE_W-1:0] share;
      logic [USED_W-1:0]  used;
      logic               ovf;
   } traverse_result_type;

   traverse_result_type pending_results[$];
   int                  error_count = 0;

   // Model state
   logic [31:0]       grid_values[MAX_POINTS];
   logic [31:0]       grid_peak;
   logic [39:0]       grid_root_sum;
   int                grid_count;
   logic              grid_dropped;
   logic [COEF_W-1:0] tube_coef;

   pitot_traverse_averager_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_reading(req_reading), .req_last_point(req_last_point),
      .rsp_valid(rsp_valid),
      .rsp_mean_velocity_pressure(rsp_mean_velocity_pressure),
      .rsp_share_above_tenth(rsp_share_above_tenth),
      .rsp_points_used(rsp_points_used), .rsp_overflow(rsp_overflow),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic void clear_grid();
      grid_peak = 0;
      grid_root_sum = 0;
      grid_count = 0;
      grid_dropped = 0;
   endfunction

   // Advance the model by one reading; queue a result on the last point
   function automatic void predict_reading(logic [RD_W-1:0] rd, logic last);
      logic [31:0]  v;
      logic [63:0]  cc;
      logic [63:0]  prod;
      logic [127:0] sq;
      logic [127:0] mean;
      logic [63:0]  n;
      int           k;
      traverse_result_type r;
      v = 0;
      if (!rd[RD_W-1] && rd != 0) begin
         cc = 64'(tube_coef) * 64'(tube_coef);
         prod = 64'(rd) * cc + (64'd1 << 31);
         v = prod[63:32];
      end
      if (grid_count < MAX_POINTS) begin
         grid_values[grid_count] = v;
         grid_count++;
         if (v > grid_peak) grid_peak = v;
         grid_root_sum = grid_root_sum + 40'(floor_sqrt(64'(v) << 16));
      end else begin
         grid_dropped = 1;
      end
      if (!last) return;
      n = grid_count;
      sq = 128'(grid_root_sum) * 128'(grid_root_sum);
      mean = sq / (128'(n * n) << 16);
      if (mean > 128'hFFFF_FFFF) mean = 128'hFFFF_FFFF;
      k = 0;
      for (int i = 0; i < grid_count; i++)
         if (64'(grid_values[i]) * 10 > 64'(grid_peak)) k++;
      r.mean  = mean[31:0];
      r.share = SHARE_W'((64'(k) << 16) / n);
      r.used  = n[7:0];
      r.ovf   = grid_dropped;
      pending_results.push_back(r);
      clear_grid();
   endfunction

   task automatic report_mismatch(string what, longint got, longint exp_val);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp_val, $realtime);
      error_count++;
   endtask

   // Check each result against the oldest expectation
   always @(posedge clock) begin
      traverse_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            e = pending_results.pop_front();
            if (rsp_mean_velocity_pressure !== e.mean)
               report_mismatch("mean", rsp_mean_velocity_pressure, e.mean);
            if (rsp_share_above_tenth !== e.share)
               report_mismatch("share", rsp_share_above_tenth, e.share);
            if (rsp_points_used !== e.used)
               report_mismatch("points_used", rsp_points_used, e.used);
            if (rsp_overflow !== e.ovf)
               report_mismatch("overflow", rsp_overflow, e.ovf);
         end
      end
   end

   // Sender gap pattern: bursts and random pauses
   int burst_left = 0;

   // Hold start high through a burst; drop it only for a pause
   task automatic send_reading(logic [RD_W-1:0] rd, logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_reading <= rd;
      req_last_point <= last;
      predict_reading(rd, last);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Wait for all results, then drain the pipeline before a write
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_coef(logic [COEF_W-1:0] c);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= c;
      @(posedge clock);
      csr_we <= 1'b0;
      tube_coef = c;
   endtask

   function automatic logic [RD_W-1:0] random_reading();
      case ($urandom_range(0, 7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'(-$urandom_range(1, 5000));
         3: return 24'(0);
         4: return 24'($urandom_range(1, 100));
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      send_reading(24'h7FFFFF, 1'b0);
      send_reading(24'h800000, 1'b0);
      send_reading(24'h000000, 1'b0);
      send_reading(24'h000001, 1'b0);
      send_reading(24'h010000, 1'b1);
      send_reading(24'h7FFFFF, 1'b1);
      send_reading(24'hFFFFFF, 1'b1);
      send_reading(24'h000000, 1'b1);
      send_reading(24'h000010, 1'b0);
      send_reading(24'h000100, 1'b0);
      send_reading(24'h000A00, 1'b1);
   endtask

   task automatic test_capacity();
      for (int i = 0; i < MAX_POINTS + 5; i++)
         send_reading(random_reading(), i == MAX_POINTS + 4);
      for (int i = 0; i < MAX_POINTS; i++)
         send_reading(random_reading(), i == MAX_POINTS - 1);
   endtask

   task automatic test_random(int items);
      int len;
      while (items > 0) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140)
                                           : $urandom_range(1, 20);
         for (int i = 0; i < len; i++) send_reading(random_reading(), i == len - 1);
         items -= len;
      end
   endtask

   task automatic test_coefficients();
      write_coef(17'h1FFFF);
      test_random(150);
      write_coef(17'h0);
      test_random(80);
      write_coef(17'h10000);
      test_random(150);
      for (int j = 0; j < 4; j++) begin
         write_coef(17'($urandom));
         test_random(150);
      end
   endtask

   initial begin
      tube_coef = COEF_RESET;
      clear_grid();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity();
      test_random(100);
      test_coefficients();
      wait_idle();
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
